// ----- design/hbb_pkg.sv -----
package hbb_pkg;

    localparam int PIX_W   = 16;
    localparam int COUNT_W = 24;
    localparam int BOX_W   = 12;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int NUM_W   = 24;
    localparam int DIV_STEPS = NUM_W;
    localparam int DCNT_W  = 5;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;
    localparam logic [NUM_W-1:0]   HUE_UNIT  = 24'd7680;
    localparam logic [NUM_W-1:0]   HUE_FULL  = 24'd46080;
    localparam logic [NUM_W-1:0]   HUE_GREEN = 24'd15360;
    localparam logic [NUM_W-1:0]   HUE_BLUE  = 24'd30720;

    localparam logic [7:0]  RST_STRIDE    = 8'd4;
    localparam logic [23:0] RST_MIN_COUNT = 24'd20;
    localparam logic [7:0]  RST_HUE_LOW   = 8'd50;
    localparam logic [7:0]  RST_HUE_HIGH  = 8'd88;
    localparam logic [8:0]  RST_SAT_MIN   = 9'd79;
    localparam logic [7:0]  RST_VALUE_MIN = 8'd51;
    localparam logic [12:0] RST_WIDTH     = 13'd320;

    typedef enum logic [IDX_W-1:0] {
        REG_STRIDE    = 3'd0,
        REG_MIN_COUNT = 3'd1,
        REG_HUE_LOW   = 3'd2,
        REG_HUE_HIGH  = 3'd3,
        REG_SAT_MIN   = 3'd4,
        REG_VALUE_MIN = 3'd5,
        REG_WIDTH     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic update;
        logic report;
    } hbb_cmd_t;

    typedef struct packed {
        logic cand;
        logic last;
        logic out_full;
    } hbb_sts_t;

endpackage

// ----- design/hbb_ctrl.sv -----
module hbb_ctrl
    import hbb_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output hbb_cmd_t cmd,
    input  hbb_sts_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_UPDATE,
        ST_REPORT
    } state_t;

    state_t state_reg, state_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;

    always_comb begin
        state_next = state_reg;
        dcnt_next  = dcnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_PREP;
            end
            ST_PREP: begin
                dcnt_next  = '0;
                state_next = sts.cand ? ST_DIV : ST_UPDATE;
            end
            ST_DIV: begin
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_STEPS - 1)) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                state_next = sts.last ? ST_REPORT : ST_IDLE;
            end
            ST_REPORT: begin
                if (!sts.out_full) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            dcnt_reg  <= '0;
        end else begin
            state_reg <= state_next;
            dcnt_reg  <= dcnt_next;
        end
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign cmd.load     = (state_reg == ST_IDLE) && s_valid;
    assign cmd.prep     = (state_reg == ST_PREP);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.update   = (state_reg == ST_UPDATE);
    assign cmd.report   = (state_reg == ST_REPORT) && !sts.out_full;

endmodule

// ----- design/hbb_datapath.sv -----
module hbb_datapath
    import hbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  hbb_cmd_t           cmd,
    output hbb_sts_t           sts,
    input  logic               cfg_valid,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic [PIX_W-1:0]   s_pixel_rgb565,
    input  logic               s_frame_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_detected,
    output logic [COUNT_W-1:0] m_match_count,
    output logic [BOX_W-1:0]   m_box_left,
    output logic [BOX_W-1:0]   m_box_top,
    output logic [BOX_W-1:0]   m_box_right,
    output logic [BOX_W-1:0]   m_box_bottom
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [13:0] MAXW = 14'(MAX_WIDTH);
    localparam logic [13:0] MAXH = 14'(MAX_HEIGHT);

    // configuration
    logic [7:0]  stride_reg, hue_low_reg, hue_high_reg, value_min_reg;
    logic [23:0] min_count_reg;
    logic [8:0]  sat_min_reg;
    logic [12:0] width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_reg    <= RST_STRIDE;
            min_count_reg <= RST_MIN_COUNT;
            hue_low_reg   <= RST_HUE_LOW;
            hue_high_reg  <= RST_HUE_HIGH;
            sat_min_reg   <= RST_SAT_MIN;
            value_min_reg <= RST_VALUE_MIN;
            width_reg     <= RST_WIDTH;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_STRIDE:    stride_reg    <= cfg_data[7:0];
                REG_MIN_COUNT: min_count_reg <= cfg_data[23:0];
                REG_HUE_LOW:   hue_low_reg   <= cfg_data[7:0];
                REG_HUE_HIGH:  hue_high_reg  <= cfg_data[7:0];
                REG_SAT_MIN:   sat_min_reg   <= cfg_data[8:0];
                REG_VALUE_MIN: value_min_reg <= cfg_data[7:0];
                REG_WIDTH:     width_reg     <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // raster position and sampling phases
    logic [CW-1:0] col_reg, cur_col_reg;
    logic [RW-1:0] row_reg, cur_row_reg;
    logic [7:0]    col_ph_reg, row_ph_reg;
    logic [PIX_W-1:0] pix_reg;
    logic last_reg, samp_reg;

    logic [13:0] width_eff;
    logic        row_wrap;
    logic [8:0]  col_ph_inc, row_ph_inc;
    logic [7:0]  col_ph_next, row_ph_next;

    always_comb begin
        width_eff   = ({1'b0, width_reg} > MAXW) ? MAXW : {1'b0, width_reg};
        row_wrap    = (14'(col_reg) + 14'd1) >= width_eff;
        col_ph_inc  = {1'b0, col_ph_reg} + 9'd1;
        row_ph_inc  = {1'b0, row_ph_reg} + 9'd1;
        col_ph_next = (col_ph_inc >= {1'b0, stride_reg}) ? 8'd0 : col_ph_inc[7:0];
        row_ph_next = (row_ph_inc >= {1'b0, stride_reg}) ? 8'd0 : row_ph_inc[7:0];
    end

    // classification
    logic [7:0] r8, g8, b8, mx, mn, dd, hp, hq;
    logic [NUM_W-1:0] hbase;
    logic cand_now, red_max;

    always_comb begin
        r8 = {pix_reg[15:11], pix_reg[15:13]};
        g8 = {pix_reg[10:5], pix_reg[10:9]};
        b8 = {pix_reg[4:0], pix_reg[4:2]};
        mx = r8;
        mn = r8;
        if (g8 > mx) mx = g8;
        if (b8 > mx) mx = b8;
        if (g8 < mn) mn = g8;
        if (b8 < mn) mn = b8;
        dd = mx - mn;
        cand_now = samp_reg && (dd != 8'd0)
                   && ({1'b0, dd, 8'd0} >= 17'(sat_min_reg) * 17'(mx))
                   && (mx >= value_min_reg);
        red_max = 1'b0;
        if (mx == g8) begin
            hp = b8; hq = r8; hbase = HUE_GREEN;
        end else if (mx == r8) begin
            hp = g8; hq = b8; hbase = HUE_FULL; red_max = 1'b1;
        end else begin
            hp = r8; hq = g8; hbase = HUE_BLUE;
        end
    end

    // divider: numerator shifts out, quotient shifts in
    logic [NUM_W-1:0] num_reg;
    logic [7:0]       rem_reg, d_reg;
    logic             red_reg, cand_reg;
    logic [8:0]       rem_sh;
    logic             qbit;

    always_comb begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        qbit   = rem_sh >= {1'b0, d_reg};
    end

    // hue window
    logic [NUM_W-1:0] hue_q;
    logic lo_ok, hi_ok, hue_ok, hit;

    always_comb begin
        hue_q = num_reg;
        if (red_reg && (hue_q >= HUE_FULL)) hue_q = hue_q - HUE_FULL;
        lo_ok  = hue_q >= {8'd0, hue_low_reg, 8'd0};
        hi_ok  = hue_q <= {8'd0, hue_high_reg, 8'd0};
        hue_ok = (hue_low_reg <= hue_high_reg) ? (lo_ok && hi_ok) : (lo_ok || hi_ok);
        hit    = cand_reg && hue_ok;
    end

    // frame accumulators
    logic [COUNT_W-1:0] count_reg;
    logic [CW-1:0] min_col_reg, max_col_reg;
    logic [RW-1:0] min_row_reg, max_row_reg;
    logic any_reg, out_full_reg, det;

    assign det = any_reg && (count_reg >= min_count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            col_ph_reg  <= '0;
            row_ph_reg  <= '0;
            count_reg   <= '0;
            min_col_reg <= '1;
            min_row_reg <= '1;
            max_col_reg <= '0;
            max_row_reg <= '0;
            any_reg     <= 1'b0;
            out_full_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                if (row_wrap) begin
                    col_reg    <= '0;
                    col_ph_reg <= '0;
                    if ((14'(row_reg) + 14'd1) < MAXH) row_reg <= row_reg + RW'(1);
                    row_ph_reg <= row_ph_next;
                end else begin
                    col_reg    <= col_reg + CW'(1);
                    col_ph_reg <= col_ph_next;
                end
            end
            if (cmd.update && hit) begin
                if (count_reg != COUNT_MAX) count_reg <= count_reg + COUNT_W'(1);
                if (!any_reg || cur_col_reg < min_col_reg) min_col_reg <= cur_col_reg;
                if (!any_reg || cur_col_reg > max_col_reg) max_col_reg <= cur_col_reg;
                if (!any_reg || cur_row_reg < min_row_reg) min_row_reg <= cur_row_reg;
                if (!any_reg || cur_row_reg > max_row_reg) max_row_reg <= cur_row_reg;
                any_reg <= 1'b1;
            end
            if (cmd.report) begin
                out_full_reg <= 1'b1;
                col_reg     <= '0;
                row_reg     <= '0;
                col_ph_reg  <= '0;
                row_ph_reg  <= '0;
                count_reg   <= '0;
                min_col_reg <= '1;
                min_row_reg <= '1;
                max_col_reg <= '0;
                max_row_reg <= '0;
                any_reg     <= 1'b0;
            end else if (m_ready) begin
                out_full_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_reg     <= s_pixel_rgb565;
            last_reg    <= s_frame_end;
            samp_reg    <= (col_ph_reg == 8'd0) && (row_ph_reg == 8'd0);
            cur_col_reg <= col_reg;
            cur_row_reg <= row_reg;
        end
        if (cmd.prep) begin
            cand_reg <= cand_now;
            red_reg  <= red_max;
            d_reg    <= dd;
            rem_reg  <= '0;
            num_reg  <= hbase * NUM_W'(dd) + HUE_UNIT * NUM_W'(hp) - HUE_UNIT * NUM_W'(hq);
        end
        if (cmd.div_step) begin
            rem_reg <= qbit ? 8'(rem_sh - {1'b0, d_reg}) : rem_sh[7:0];
            num_reg <= {num_reg[NUM_W-2:0], qbit};
        end
        if (cmd.report) begin
            m_detected    <= det;
            m_match_count <= det ? count_reg : '0;
            m_box_left    <= det ? BOX_W'(min_col_reg) : '0;
            m_box_top     <= det ? BOX_W'(min_row_reg) : '0;
            m_box_right   <= det ? BOX_W'(max_col_reg) : '0;
            m_box_bottom  <= det ? BOX_W'(max_row_reg) : '0;
        end
    end

    assign m_valid      = out_full_reg;
    assign sts.cand     = cand_now;
    assign sts.last     = last_reg;
    assign sts.out_full = out_full_reg;

endmodule

// ----- design/hsv_color_blob_bounding_box_unit.sv -----
// channel   dir  signals                                   beat
// s_        in   s_valid s_ready s_pixel_rgb565 s_frame_end  one pixel
// m_        out  m_valid m_ready m_detected m_match_count    one frame report
//                m_box_left m_box_top m_box_right m_box_bottom
// cfg_      in   cfg_valid cfg_ready cfg_index cfg_data      one register write
// a pixel outside the sampling grid or failing the gray, saturation or value
// tests passes the load, prep and update states; a candidate pixel also runs the
// 24-step restoring hue divider after prep. a frame-end pixel adds a report state.
// reset is synchronous, active low; cfg registers return to defaults, frame cleared.
// the report sits in an output register, so pixels keep flowing while m_ready is low
// until the next frame end needs that register.
module hsv_color_blob_bounding_box_unit
    import hbb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIX_W-1:0]   s_pixel_rgb565,
    input  logic               s_frame_end,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_detected,
    output logic [COUNT_W-1:0] m_match_count,
    output logic [BOX_W-1:0]   m_box_left,
    output logic [BOX_W-1:0]   m_box_top,
    output logic [BOX_W-1:0]   m_box_right,
    output logic [BOX_W-1:0]   m_box_bottom
);

    hbb_cmd_t cmd;
    hbb_sts_t sts;

    assign cfg_ready = 1'b1;

    hbb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    hbb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_pixel_rgb565 (s_pixel_rgb565),
        .s_frame_end    (s_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_detected     (m_detected),
        .m_match_count  (m_match_count),
        .m_box_left     (m_box_left),
        .m_box_top      (m_box_top),
        .m_box_right    (m_box_right),
        .m_box_bottom   (m_box_bottom)
    );

`ifndef ASSERT_OFF
    a_one_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("pixel accepted while previous still in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |-> !m_valid)
        else $error("report overwrote a pending result");

    a_div_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> !s_ready && !cmd.update)
        else $error("divider stepping outside its window");

    a_report_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(cmd.report))
        else $error("result appeared without a report");
`endif

endmodule

// ----- test/tb_hsv_color_blob_bounding_box_unit.sv -----
module tb_hsv_color_blob_bounding_box_unit;
    import hbb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = 4096;
    localparam int MAX_H = 4096;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic               detected;
        logic [COUNT_W-1:0] match_count;
        logic [BOX_W-1:0]   left;
        logic [BOX_W-1:0]   top;
        logic [BOX_W-1:0]   right;
        logic [BOX_W-1:0]   bottom;
    } frame_report_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [PIX_W-1:0]   s_pixel_rgb565;
    logic               s_frame_end;
    logic               m_valid;
    logic               m_ready;
    logic               m_detected;
    logic [COUNT_W-1:0] m_match_count;
    logic [BOX_W-1:0]   m_box_left;
    logic [BOX_W-1:0]   m_box_top;
    logic [BOX_W-1:0]   m_box_right;
    logic [BOX_W-1:0]   m_box_bottom;

    hsv_color_blob_bounding_box_unit i_dut (.*);

    // register copies
    int unsigned stride_r, min_count_r, hue_lo_r, hue_hi_r, sat_min_r, val_min_r, width_r;
    // frame tracking state
    int unsigned col_pos, row_pos, col_ph, row_ph, hits;
    int unsigned min_col, min_row, max_col, max_row;
    bit          any_hit;

    frame_report_t report_q[$];
    int  errors;
    int  pixels_sent;
    int  reports_seen;
    int  detections_seen;
    int  send_idle_pct;
    int  recv_stall_pct;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void clear_frame_state();
        col_pos = 0; row_pos = 0; col_ph = 0; row_ph = 0; hits = 0;
        min_col = 12'hFFF; min_row = 12'hFFF; max_col = 0; max_row = 0;
        any_hit = 1'b0;
    endfunction

    function automatic int unsigned widen5(int unsigned v);
        return (v << 3) | (v >> 2);
    endfunction

    function automatic bit hsv_in_window(logic [15:0] px);
        int unsigned r, g, b, mx, mn, d, h;
        r = widen5(px[15:11]);
        g = (px[10:5] << 2) | (px[10:5] >> 4);
        b = widen5(px[4:0]);
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (d == 0) return 1'b0;
        if (d * 256 < sat_min_r * mx) return 1'b0;
        if (mx < val_min_r) return 1'b0;
        if (mx == g) h = (15360 * d + 7680 * b - 7680 * r) / d;
        else if (mx == r) begin
            h = (46080 * d + 7680 * g - 7680 * b) / d;
            if (h >= 46080) h -= 46080;
        end else h = (30720 * d + 7680 * r - 7680 * g) / d;
        if (hue_lo_r <= hue_hi_r) return h >= hue_lo_r * 256 && h <= hue_hi_r * 256;
        return h >= hue_lo_r * 256 || h <= hue_hi_r * 256;
    endfunction

    function automatic int unsigned next_phase(int unsigned ph);
        int unsigned n;
        n = ph + 1;
        return (n >= stride_r) ? 0 : n;
    endfunction

    function automatic void track_pixel(logic [15:0] px, logic last);
        int unsigned w;
        frame_report_t rep;
        bit det;
        w = (width_r == 0) ? 1 : width_r;
        if (w > MAX_W) w = MAX_W;
        if (col_ph == 0 && row_ph == 0 && hsv_in_window(px)) begin
            if (hits < 32'hFFFFFF) hits++;
            if (!any_hit || col_pos < min_col) min_col = col_pos;
            if (!any_hit || col_pos > max_col) max_col = col_pos;
            if (!any_hit || row_pos < min_row) min_row = row_pos;
            if (!any_hit || row_pos > max_row) max_row = row_pos;
            any_hit = 1'b1;
        end
        if (col_pos + 1 >= w) begin
            col_pos = 0; col_ph = 0;
            if (row_pos + 1 < MAX_H) row_pos++;
            row_ph = next_phase(row_ph);
        end else begin
            col_pos++;
            col_ph = next_phase(col_ph);
        end
        if (last) begin
            det = any_hit && hits >= min_count_r;
            rep = '0;
            if (det) begin
                rep.detected = 1'b1;
                rep.match_count = COUNT_W'(hits);
                rep.left = BOX_W'(min_col); rep.top = BOX_W'(min_row);
                rep.right = BOX_W'(max_col); rep.bottom = BOX_W'(max_row);
            end
            report_q.push_back(rep);
            clear_frame_state();
        end
    endfunction

    task automatic write_reg(reg_idx_t idx, int unsigned value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_STRIDE:    stride_r    = value & 8'hFF;
            REG_MIN_COUNT: min_count_r = value & 24'hFFFFFF;
            REG_HUE_LOW:   hue_lo_r    = value & 8'hFF;
            REG_HUE_HIGH:  hue_hi_r    = value & 8'hFF;
            REG_SAT_MIN:   sat_min_r   = value & 9'h1FF;
            REG_VALUE_MIN: val_min_r   = value & 8'hFF;
            REG_WIDTH:     width_r     = value & 13'h1FFF;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [15:0] px, logic last);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_valid        <= 1'b1;
        s_pixel_rgb565 <= px;
        s_frame_end    <= last;
        do @(posedge aclk); while (!s_ready);
        track_pixel(px, last);
        pixels_sent++;
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // wait for the queue to drain, then cover a full pixel pass
    task automatic drain();
        while (report_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        frame_report_t exp_rep;
        if (aresetn && m_valid && m_ready) begin
            reports_seen++;
            if (report_q.size() == 0) begin
                $error("frame report with no expectation");
                errors++;
            end else begin
                exp_rep = report_q.pop_front();
                if (m_detected) detections_seen++;
                if (m_detected !== exp_rep.detected) begin
                    $error("detected exp %0d got %0d", exp_rep.detected, m_detected);
                    errors++;
                end
                if (m_match_count !== exp_rep.match_count) begin
                    $error("match_count exp %0d got %0d", exp_rep.match_count, m_match_count);
                    errors++;
                end
                if (m_box_left !== exp_rep.left) begin
                    $error("box_left exp %0d got %0d", exp_rep.left, m_box_left);
                    errors++;
                end
                if (m_box_top !== exp_rep.top) begin
                    $error("box_top exp %0d got %0d", exp_rep.top, m_box_top);
                    errors++;
                end
                if (m_box_right !== exp_rep.right) begin
                    $error("box_right exp %0d got %0d", exp_rep.right, m_box_right);
                    errors++;
                end
                if (m_box_bottom !== exp_rep.bottom) begin
                    $error("box_bottom exp %0d got %0d", exp_rep.bottom, m_box_bottom);
                    errors++;
                end
            end
        end
    end

    // mostly saturated colors near the hue window, some gray and noise
    function automatic logic [15:0] random_pixel();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 2) return 16'($urandom());
        if (sel == 2) begin
            sel = $urandom_range(31);
            return {sel[4:0], sel[4:0], 1'b0, sel[4:0]};
        end
        case ($urandom_range(2))
            0: return {5'($urandom_range(31, 12)), 6'($urandom_range(20)),
                       5'($urandom_range(10))};
            1: return {5'($urandom_range(10)), 6'($urandom_range(63, 24)),
                       5'($urandom_range(12))};
            default: return {5'($urandom_range(12)), 6'($urandom_range(24)),
                             5'($urandom_range(31, 12))};
        endcase
    endfunction

    task automatic send_frame(int unsigned n_pix);
        for (int unsigned i = 0; i < n_pix; i++) send_pixel(random_pixel(), i == n_pix - 1);
    endtask

    task automatic test_directed();
        logic [15:0] corner_px[12];
        corner_px = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'hFFE0,
                      16'h07FF, 16'hF81F, 16'h8410, 16'h4208, 16'hAAAA, 16'h5555};
        // starting from reset defaults, set stride and width tiny so all is sampled
        write_reg(REG_STRIDE, 1);
        write_reg(REG_WIDTH, 4);
        write_reg(REG_MIN_COUNT, 1);
        write_reg(REG_HUE_LOW, 0);
        write_reg(REG_HUE_HIGH, 180);
        write_reg(REG_SAT_MIN, 0);
        write_reg(REG_VALUE_MIN, 0);
        foreach (corner_px[i]) send_pixel(corner_px[i], i == 5 || i == 11);
        drain();
        // wrapped window around red, min count, stride and width zero, then saturation above full
        write_reg(REG_HUE_LOW, 170);
        write_reg(REG_HUE_HIGH, 10);
        write_reg(REG_MIN_COUNT, 0);
        write_reg(REG_STRIDE, 0);
        write_reg(REG_WIDTH, 0);
        send_pixel(16'hF800, 1'b0);
        send_pixel(16'hF810, 1'b1);
        send_pixel(16'hF800, 1'b1);
        drain();
        write_reg(REG_SAT_MIN, 257);
        send_pixel(16'hF800, 1'b1);
        drain();
        write_reg(REG_SAT_MIN, 256);
        write_reg(REG_VALUE_MIN, 255);
        write_reg(REG_HUE_LOW, 255);
        write_reg(REG_HUE_HIGH, 255);
        send_pixel(16'hF800, 1'b0);
        send_pixel(16'h07E0, 1'b1);
        drain();
    endtask

    task automatic test_random_phase(int idle, int stall, int n_frames);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int f = 0; f < n_frames; f++) begin
            if ($urandom_range(3) == 0) begin
                drain();
                write_reg(REG_STRIDE, $urandom_range(3, 1));
                write_reg(REG_WIDTH, $urandom_range(12, 1));
                write_reg(REG_MIN_COUNT, $urandom_range(3));
                write_reg(REG_HUE_LOW, $urandom_range(180));
                write_reg(REG_HUE_HIGH, $urandom_range(180));
                write_reg(REG_SAT_MIN, $urandom_range(256));
                write_reg(REG_VALUE_MIN, $urandom_range(255));
            end
            send_frame($urandom_range(40, 1));
        end
        drain();
    endtask

    // wide rows and large registers, few items
    task automatic test_extremes();
        send_idle_pct = 0; recv_stall_pct = 0;
        write_reg(REG_STRIDE, 255);
        write_reg(REG_WIDTH, 8191);
        write_reg(REG_MIN_COUNT, 24'hFFFFFF);
        send_frame(20);
        drain();
        write_reg(REG_WIDTH, 4096);
        write_reg(REG_STRIDE, 1);
        write_reg(REG_MIN_COUNT, 1);
        write_reg(REG_HUE_LOW, 0);
        write_reg(REG_HUE_HIGH, 180);
        write_reg(REG_SAT_MIN, 0);
        write_reg(REG_VALUE_MIN, 0);
        send_frame(20);
        drain();
    endtask

    initial begin
        errors = 0; pixels_sent = 0; reports_seen = 0; detections_seen = 0;
        send_idle_pct = 0; recv_stall_pct = 0; cycles = 0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        s_valid = 1'b0; s_pixel_rgb565 = '0; s_frame_end = 1'b0;
        m_ready = 1'b1;
        stride_r = RST_STRIDE; min_count_r = RST_MIN_COUNT; hue_lo_r = RST_HUE_LOW;
        hue_hi_r = RST_HUE_HIGH; sat_min_r = RST_SAT_MIN; val_min_r = RST_VALUE_MIN;
        width_r = RST_WIDTH;
        clear_frame_state();
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_extremes();
        test_random_phase(0, 0, 13);
        test_random_phase(51, 0, 13);
        test_random_phase(0, 51, 13);
        test_random_phase(11, 11, 13);
        test_random_phase(0, 0, 7);
        drain();
        $display("sent %0d pixels, checked %0d frame reports (%0d detections)",
                 pixels_sent, reports_seen, detections_seen);
        $display("covered strides, widths, wrapped hue windows and idle/stall mixes");
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// ----- hsv_color_blob_bounding_box_unit.f -----
design/hbb_pkg.sv
design/hbb_ctrl.sv
design/hbb_datapath.sv
design/hsv_color_blob_bounding_box_unit.sv
test/tb_hsv_color_blob_bounding_box_unit.sv
